// ===== sv/rle_channel_encoder_assert.svh =====
// Assertion helpers for the run-length encoder.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef RLE_CHANNEL_ENCODER_ASSERT_SVH
`define RLE_CHANNEL_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rce_pkg.sv =====
`default_nettype none

package rce_pkg;

    localparam int RCE_MAX_SEGMENT = 128;
    localparam int LANE_BYTES      = 8;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 4;
    localparam int FIX_SLOTS       = 4;
    localparam int FIX_IDX_W       = $clog2(FIX_SLOTS);
    localparam int FIX_CNT_W       = $clog2(FIX_SLOTS + 1);
    localparam int LANE_IDX_W      = $clog2(LANE_BYTES);

    localparam logic [BYTE_W-1:0] RUN_FLAG    = 8'h80;
    localparam logic [BYTE_W-1:0] LIT_ONE_HDR = 8'h00;

    typedef logic [BYTE_W-1:0]                  byte_t;
    typedef logic [FIX_SLOTS-1:0][BYTE_W-1:0]   fix_t;
    typedef logic [LANE_BYTES-1:0][BYTE_W-1:0]  lane_t;

endpackage

`default_nettype wire

// ===== sv/rle_channel_encoder.sv =====
`default_nettype none
`include "rle_channel_encoder_assert.svh"

// Channel  Direction  Handshake             Word payload
// -------  ---------  --------------------  ---------------------------------------------
// in       input      in_valid / in_stall   data_byte, end_of_channel
// out      output     out_valid / out_stall packed_bytes, byte_count, group_last,
//                                           channel_last
//
// A byte that closes no segment leaves in_stall low; one that closes segments holds it high
// until the N encoded bytes it releases (up to MAX_SEGMENT + 1) have left stage 1, since
// the store has one read port; the sequencer moves one encoded byte per unstalled cycle.
// rst_n clears segment and handshake state; the literal store needs no clearing pass.
// in_stall is high while the sequencer owes bytes; a finished word waits in the output
// register, so out_stall holds the sequencer only once the next word is complete.
module rle_channel_encoder
    import rce_pkg::*;
#(
    parameter int MAX_SEGMENT = RCE_MAX_SEGMENT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [BYTE_W-1:0]              data_byte,
    input  wire logic                           end_of_channel,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [LANE_BYTES*BYTE_W-1:0]        packed_bytes,
    output logic [COUNT_W-1:0]                  byte_count,
    output logic                                group_last,
    output logic                                channel_last
);

    localparam int LEN_W  = $clog2(MAX_SEGMENT + 1);
    localparam int ADDR_W = $clog2(MAX_SEGMENT);
    localparam int POS_W  = $clog2(MAX_SEGMENT + 6);

    localparam logic [LEN_W-1:0] SEG_MAX = LEN_W'(MAX_SEGMENT);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LIT  = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    function automatic byte_t run_hdr(input logic [LEN_W-1:0] n);
        return RUN_FLAG | {1'b0, 7'(n - LEN_W'(1))};
    endfunction

    function automatic byte_t lit_hdr(input logic [LEN_W-1:0] n);
        return {1'b0, 7'(n - LEN_W'(1))};
    endfunction

    // ------------------------------------------------------------------
    // Segment state
    // ------------------------------------------------------------------
    logic [1:0]         mode_reg, mode_next;
    logic [LEN_W-1:0]   lit_len_reg, lit_len_next;
    byte_t              run_val_reg, run_val_next;
    logic [LEN_W-1:0]   run_len_reg, run_len_next;
    // Last two literal bytes, kept beside the store so that the three-equal check
    // needs no read.
    byte_t              tail1_reg, tail1_next;
    byte_t              tail2_reg, tail2_next;

    // Literal store: one write port at item acceptance, one registered read port
    // driven by the byte sequencer.
    byte_t              lit_mem [MAX_SEGMENT];
    byte_t              mem_rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    // Emission plan of the current item: optional literal (header plus store
    // bytes), then up to four fixed bytes (run codes, one-byte literal).
    logic               plan_lit_en;
    logic [LEN_W-1:0]   plan_lit_n;
    fix_t               plan_fix;
    logic [FIX_CNT_W-1:0] plan_fix_cnt;
    logic [POS_W-1:0]   plan_lit_part;
    logic [POS_W-1:0]   plan_total;

    logic               open_run;
    logic [LEN_W-1:0]   run_n;
    logic [LEN_W-1:0]   rl_inc;
    logic               start_seg;
    logic               start_slot2;

    logic               in_take;

    // ------------------------------------------------------------------
    // Byte sequencer and lane packer
    // ------------------------------------------------------------------
    logic               busy_reg, busy_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   total_reg;
    logic [POS_W-1:0]   lit_part_reg;
    byte_t              lit_hdr_reg;
    fix_t               fix_reg;
    logic               eoc_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_mem_reg, s1_mem_next;
    byte_t              s1_byte_reg, s1_byte_next;
    logic               s1_last_reg, s1_last_next;

    lane_t              acc_reg, acc_next;
    logic [LANE_IDX_W-1:0] acc_cnt_reg, acc_cnt_next;

    logic               out_valid_reg, out_valid_next;
    lane_t              out_data_reg, out_data_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic               out_glast_reg, out_glast_next;
    logic               out_clast_reg, out_clast_next;

    logic               in_hdr;
    logic               in_body;
    logic [FIX_IDX_W-1:0] fidx;
    byte_t              issue_byte;
    byte_t              s1_data;
    lane_t              word_build;
    logic               word_done;
    logic               out_free;
    logic               s1_take;
    logic               issue;

    assign in_take = in_valid && !in_stall;
    assign in_stall = busy_reg;

    // ------------------------------------------------------------------
    // Segment decision for one input byte
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next    = mode_reg;
        lit_len_next = lit_len_reg;
        run_val_next = run_val_reg;
        run_len_next = run_len_reg;
        tail1_next   = tail1_reg;
        tail2_next   = tail2_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        plan_lit_en  = 1'b0;
        plan_lit_n   = '0;
        plan_fix     = '0;
        plan_fix_cnt = '0;
        open_run     = 1'b0;
        run_n        = '0;
        start_seg    = 1'b0;
        start_slot2  = 1'b0;
        rl_inc       = run_len_reg + LEN_W'(1);

        case (mode_reg)
            MODE_RUN:
            begin
                if (data_byte == run_val_reg && run_len_reg < SEG_MAX) begin
                    // Extend the run.
                    open_run = 1'b1;
                    run_n    = rl_inc;
                end
                else begin
                    // Close the run, then open a fresh segment on this byte.
                    plan_fix[0]  = run_hdr(run_len_reg);
                    plan_fix[1]  = run_val_reg;
                    plan_fix_cnt = FIX_CNT_W'(2);
                    start_seg    = 1'b1;
                    start_slot2  = 1'b1;
                end
            end
            MODE_LIT:
            begin
                if (lit_len_reg != '0 && lit_len_reg < SEG_MAX) begin
                    if (lit_len_reg == LEN_W'(1) && data_byte == tail1_reg) begin
                        // Two equal leading bytes turn the segment into a run.
                        open_run = 1'b1;
                        run_n    = LEN_W'(2);
                    end
                    else if (lit_len_reg >= LEN_W'(3) && tail2_reg == data_byte &&
                             tail1_reg == data_byte) begin
                        // Three equal bytes: drop the last two from the literal.
                        plan_lit_en = 1'b1;
                        plan_lit_n  = lit_len_reg - LEN_W'(2);
                        open_run    = 1'b1;
                        run_n       = LEN_W'(3);
                    end
                    else begin
                        mem_we       = 1'b1;
                        mem_waddr    = ADDR_W'(lit_len_reg);
                        lit_len_next = lit_len_reg + LEN_W'(1);
                        tail2_next   = tail1_reg;
                        tail1_next   = data_byte;
                        if (lit_len_reg + LEN_W'(1) >= SEG_MAX || end_of_channel) begin
                            plan_lit_en  = 1'b1;
                            plan_lit_n   = lit_len_reg + LEN_W'(1);
                            mode_next    = MODE_IDLE;
                            lit_len_next = '0;
                            run_len_next = '0;
                        end
                    end
                end
                else begin
                    start_seg = 1'b1;
                end
            end
            default:
            begin
                start_seg = 1'b1;
            end
        endcase

        if (open_run) begin
            run_val_next = data_byte;
            if (run_n >= SEG_MAX || end_of_channel) begin
                plan_fix[0]  = run_hdr(run_n);
                plan_fix[1]  = data_byte;
                plan_fix_cnt = FIX_CNT_W'(2);
                mode_next    = MODE_IDLE;
                lit_len_next = '0;
                run_len_next = '0;
            end
            else begin
                mode_next    = MODE_RUN;
                lit_len_next = '0;
                run_len_next = run_n;
            end
        end

        if (start_seg) begin
            if (end_of_channel) begin
                // A lone final byte goes out as a one-byte literal.
                if (start_slot2) begin
                    plan_fix[2]  = LIT_ONE_HDR;
                    plan_fix[3]  = data_byte;
                    plan_fix_cnt = FIX_CNT_W'(4);
                end
                else begin
                    plan_fix[0]  = LIT_ONE_HDR;
                    plan_fix[1]  = data_byte;
                    plan_fix_cnt = FIX_CNT_W'(2);
                end
                mode_next    = MODE_IDLE;
                lit_len_next = '0;
                run_len_next = '0;
            end
            else begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                tail1_next   = data_byte;
                lit_len_next = LEN_W'(1);
                run_len_next = '0;
                mode_next    = MODE_LIT;
            end
        end

        plan_lit_part = plan_lit_en ? (POS_W'(plan_lit_n) + POS_W'(1)) : '0;
        plan_total    = plan_lit_part + POS_W'(plan_fix_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            lit_len_reg <= '0;
            run_val_reg <= '0;
            run_len_reg <= '0;
        end
        else if (in_take) begin
            mode_reg    <= mode_next;
            lit_len_reg <= lit_len_next;
            run_val_reg <= run_val_next;
            run_len_reg <= run_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            tail1_reg    <= tail1_next;
            tail2_reg    <= tail2_next;
            lit_part_reg <= plan_lit_part;
            total_reg    <= plan_total;
            lit_hdr_reg  <= lit_hdr(plan_lit_n);
            fix_reg      <= plan_fix;
            eoc_reg      <= end_of_channel;
        end
    end

    // Literal store. Reads are only issued while no item can be taken, so a read
    // never meets a write of the same cycle.
    always_ff @(posedge clk)
    begin
        if (in_take && mem_we) begin
            lit_mem[mem_waddr] <= data_byte;
        end
        if (rd_en) begin
            mem_rdata_reg <= lit_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Byte sequencer: walk the plan one encoded byte per unstalled cycle
    // ------------------------------------------------------------------
    assign in_hdr     = (pos_reg == '0) && (lit_part_reg != '0);
    assign in_body    = (pos_reg != '0) && (pos_reg < lit_part_reg);
    assign fidx       = FIX_IDX_W'(pos_reg - lit_part_reg);
    assign issue_byte = in_hdr ? lit_hdr_reg : fix_reg[fidx];
    assign rd_addr    = ADDR_W'(pos_reg - POS_W'(1));

    // Stage 1 holds one byte; a store byte lives in the read register, which keeps
    // its value while no new read is issued.
    assign s1_data   = s1_mem_reg ? mem_rdata_reg : s1_byte_reg;
    assign word_done = (acc_cnt_reg == LANE_IDX_W'(LANE_BYTES - 1)) || s1_last_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_take   = s1_valid_reg && (!word_done || out_free);
    assign issue     = busy_reg && (pos_reg != total_reg) && (!s1_valid_reg || s1_take);
    assign rd_en     = issue && in_body;

    always_comb
    begin
        for (int i = 0; i < LANE_BYTES; i++) begin
            if (LANE_IDX_W'(i) < acc_cnt_reg) begin
                word_build[i] = acc_reg[i];
            end
            else if (LANE_IDX_W'(i) == acc_cnt_reg) begin
                word_build[i] = s1_data;
            end
            else begin
                word_build[i] = '0;
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        s1_valid_next  = s1_valid_reg;
        s1_mem_next    = s1_mem_reg;
        s1_byte_next   = s1_byte_reg;
        s1_last_next   = s1_last_reg;
        acc_next       = acc_reg;
        acc_cnt_next   = acc_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        out_glast_next = out_glast_reg;
        out_clast_next = out_clast_reg;

        // Output register drains when the consumer takes it.
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        if (s1_take) begin
            s1_valid_next = 1'b0;
            if (word_done) begin
                out_valid_next = 1'b1;
                out_data_next  = word_build;
                out_cnt_next   = COUNT_W'(acc_cnt_reg) + COUNT_W'(1);
                out_glast_next = s1_last_reg;
                out_clast_next = s1_last_reg && eoc_reg;
                acc_cnt_next   = '0;
            end
            else begin
                acc_next     = word_build;
                acc_cnt_next = acc_cnt_reg + LANE_IDX_W'(1);
            end
            if (s1_last_reg) begin
                busy_next = 1'b0;
            end
        end

        if (issue) begin
            s1_valid_next = 1'b1;
            s1_mem_next   = in_body;
            s1_byte_next  = issue_byte;
            s1_last_next  = (pos_reg + POS_W'(1) == total_reg);
            pos_next      = pos_reg + POS_W'(1);
        end

        if (in_take) begin
            busy_next = (plan_total != '0);
            pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            s1_valid_reg  <= s1_valid_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mem_reg    <= s1_mem_next;
        s1_byte_reg   <= s1_byte_next;
        s1_last_reg   <= s1_last_next;
        acc_reg       <= acc_next;
        out_data_reg  <= out_data_next;
        out_cnt_reg   <= out_cnt_next;
        out_glast_reg <= out_glast_next;
        out_clast_reg <= out_clast_next;
    end

    assign out_valid    = out_valid_reg;
    assign packed_bytes = out_data_reg;
    assign byte_count   = out_cnt_reg;
    assign group_last   = out_glast_reg;
    assign channel_last = out_clast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RCE_ASSERT_NOW(a_take_drained, in_take, !s1_valid_reg && acc_cnt_reg == '0, "byte taken while encoded bytes in flight")
    `RCE_ASSERT_NOW(a_lit_len_range, mode_reg == MODE_LIT, lit_len_reg != '0 && lit_len_reg < SEG_MAX, "open literal length out of range")
    `RCE_ASSERT_NOW(a_pos_bound, busy_reg, pos_reg <= total_reg, "sequencer ran past the plan")
    `RCE_ASSERT_NEXT(a_read_hold, s1_valid_reg && s1_mem_reg && !s1_take, $stable(mem_rdata_reg), "held store byte changed")

endmodule

`default_nettype wire
